/* sv/wire_sphere_vertex_generator_unit_macros.svh */
// Assertion shorthands for the sphere vertex generator.
`ifndef WIRE_SPHERE_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define WIRE_SPHERE_VERTEX_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk_i outside reset.
`define WSVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSVG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/wsvg_pkg.sv */
package wsvg_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int CORD_CNT_W   = 5;
  localparam int PHASE_W      = 32;
  localparam int DIV_CNT_W    = 6;
  localparam int TRIG_W       = 32;
  localparam int COORD_W      = 17;
  localparam int MUL_A_W      = 33;
  localparam int PROD_W       = MUL_A_W + TRIG_W;

  localparam logic signed [TRIG_W-1:0]  INV_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [MUL_A_W-1:0] HALF_PI_Q31  = 33'sd3373259426;
  localparam logic signed [COORD_W-1:0] COORD_MAX    = 17'sd65535;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_SLICES = 2'd1,
    REG_STACKS = 2'd2
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV    = 7'b0000010,
    ST_ZMUL   = 7'b0000100,
    ST_CSTART = 7'b0001000,
    ST_CORD   = 7'b0010000,
    ST_MUL    = 7'b0100000,
    ST_RND    = 7'b1000000
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [CORD_CNT_W-1:0] k);
    logic signed [TRIG_W-1:0] v;
    case (k)
      5'd0:  v = 32'sh3243F6A8;
      5'd1:  v = 32'sh1DAC6705;
      5'd2:  v = 32'sh0FADBAFC;
      5'd3:  v = 32'sh07F56EA6;
      5'd4:  v = 32'sh03FEAB76;
      5'd5:  v = 32'sh01FFD55B;
      5'd6:  v = 32'sh00FFFAAA;
      5'd7:  v = 32'sh007FFF55;
      5'd8:  v = 32'sh003FFFEA;
      5'd9:  v = 32'sh001FFFFD;
      5'd10: v = 32'sh000FFFFF;
      5'd11: v = 32'sh0007FFFF;
      5'd12: v = 32'sh0003FFFF;
      5'd13: v = 32'sh0001FFFF;
      5'd14: v = 32'sh0000FFFF;
      5'd15: v = 32'sh00007FFF;
      5'd16: v = 32'sh00003FFF;
      5'd17: v = 32'sh00001FFF;
      5'd18: v = 32'sh00000FFF;
      5'd19: v = 32'sh000007FF;
      5'd20: v = 32'sh000003FF;
      5'd21: v = 32'sh000001FF;
      5'd22: v = 32'sh000000FF;
      5'd23: v = 32'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/wsvg_div.sv */
// Restoring divider: quotient of (num * 2^32 + den/2) / den, one bit a cycle.
module wsvg_div
  import wsvg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [6:0]         num_i,
  input  logic [6:0]         den_i,
  output logic               done_o,
  output logic [PHASE_W-1:0] quot_o
);

  logic [6:0]           rem_q;
  logic [6:0]           den_q;
  logic [PHASE_W-1:0]   dq_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [7:0]           trial;
  logic                 ge;
  logic [7:0]           diff;

  assign trial = {rem_q, dq_q[PHASE_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(PHASE_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      dq_q  <= {{(PHASE_W-6){1'b0}}, den_i[6:1]};
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[6:0] : trial[6:0];
      dq_q  <= {dq_q[PHASE_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

/* sv/wsvg_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation a cycle.
module wsvg_cordic
  import wsvg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [TRIG_W-1:0] z0_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [TRIG_W-1:0] x_q, y_q, z_q;
  logic [CORD_CNT_W-1:0]    k_q;
  logic                     run_q;
  logic                     done_q;
  logic signed [TRIG_W-1:0] dx, dy, ang;

  assign dx  = y_q >>> k_q;
  assign dy  = x_q >>> k_q;
  assign ang = atan_q30(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        k_q   <= '0;
      end else if (run_q) begin
        if (k_q == CORD_CNT_W'(CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= INV_GAIN_Q30;
      y_q <= '0;
      z_q <= z0_i;
    end else if (run_q) begin
      if (!z_q[TRIG_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

endmodule

/* sv/wsvg_mul.sv */
// Shared signed multiplier with registered product.
module wsvg_mul
  import wsvg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [TRIG_W-1:0]  b_i,
  output logic signed [PROD_W-1:0]  p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

/* sv/wire_sphere_vertex_generator_unit.sv */
// Channel   | Signals                                      | Direction
// ----------+----------------------------------------------+----------
// request   | start, busy, kind_i, line_index_i            | in/out
// vertex    | vertex_valid_o, vertex_x/y/z_o, closed_loop_o,| out
//           | last_vertex_o, bad_line_o                    |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,| in/out
//           | pready                                       |
//
// Each vertex takes a divider pass for its phase, the angle scaling, a CORDIC
// run and a multiply and round step per product (2 or 3 products). A line adds
// one setup pass with two products for its own terms.
// Reset clears the sequencer and loads the register defaults.
// The receiver cannot stall: a vertex is shown for one cycle on vertex_valid_o.
// A bad index answers in the cycle after the request with one flagged vertex.
module wire_sphere_vertex_generator_unit
  import wsvg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind_i,
  input  logic [5:0]                line_index_i,
  output logic                      vertex_valid_o,
  output logic signed [COORD_W-1:0] vertex_x_o,
  output logic signed [COORD_W-1:0] vertex_y_o,
  output logic signed [COORD_W-1:0] vertex_z_o,
  output logic                      closed_loop_o,
  output logic                      last_vertex_o,
  output logic                      bad_line_o
);

  // Configuration registers.
  logic [15:0] radius_q;
  logic [6:0]  slices_q;
  logic [5:0]  stacks_q;
  reg_idx_e    reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd7373;
      slices_q <= 7'd28;
      stacks_q <= 6'd18;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_RADIUS: radius_q <= pwdata[15:0];
        REG_SLICES: slices_q <= pwdata[6:0];
        REG_STACKS: stacks_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIUS: prdata = {16'd0, radius_q};
      REG_SLICES: prdata = {25'd0, slices_q};
      REG_STACKS: prdata = {26'd0, stacks_q};
      default:    prdata = '0;
    endcase
  end

  // Clamp the counts to their legal ranges.
  logic [6:0] n_sl_c;
  logic [5:0] n_st_c;
  always_comb begin
    n_sl_c = slices_q;
    if (slices_q < 7'd3) n_sl_c = 7'd3;
    if (slices_q > 7'(MAX_POINTS)) n_sl_c = 7'(MAX_POINTS);
    n_st_c = (stacks_q < 6'd2) ? 6'd2 : stacks_q;
  end

  // Sequencer state.
  state_e state_q, state_d;
  logic       kind_q;
  logic       pass_q;     // 0 line terms, 1 points
  logic [6:0] k_q;
  logic [1:0] mstep_q;
  logic [1:0] quad_q;
  logic [6:0] n_sl_q;
  logic [5:0] n_st_q;
  logic signed [TRIG_W-1:0]  c_q, s_q;
  logic signed [COORD_W-1:0] fixed_q, scale_q;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic closed_q, last_q, bad_q, valid_q;

  // Shared units.
  logic                     div_start;
  logic [6:0]               div_num, div_den;
  logic                     div_done;
  logic [PHASE_W-1:0]       phase;
  logic                     cord_start;
  logic                     cord_done;
  logic signed [TRIG_W-1:0] cord_c, cord_s;
  logic signed [TRIG_W-1:0] z0;
  logic                     mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [TRIG_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod;

  wsvg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (phase)
  );

  wsvg_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .z0_i   (z0),
    .done_o (cord_done),
    .cos_o  (cord_c),
    .sin_o  (cord_s)
  );

  wsvg_mul u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // Request decode.
  logic accept, bad_req;
  assign accept  = start && (state_q == ST_IDLE);
  assign bad_req = kind_i ? ({1'b0, line_index_i} >= n_sl_c)
                          : ((line_index_i == 6'd0) || (line_index_i >= n_st_c));

  // Quarter-turn reduction of the phase.
  logic [1:0]         quad;
  logic [PHASE_W-1:0] qsum, rem_ph;
  assign qsum   = phase + 32'h2000_0000;
  assign quad   = qsum[PHASE_W-1:PHASE_W-2];
  assign rem_ph = phase - {quad, 30'd0};

  // Scale the angle product to Q30 radians, round half up.
  logic signed [PROD_W-1:0] zsum;
  assign zsum = prod + (PROD_W'(1) <<< 30);
  assign z0   = zsum[62:31];

  // Product rounding and saturation to coordinate range.
  logic signed [PROD_W-1:0] rsum;
  logic signed [34:0]       rv;
  logic signed [COORD_W-1:0] rsat;
  assign rsum = prod + (PROD_W'(1) <<< 29);
  assign rv   = rsum[64:30];
  always_comb begin
    rsat = rv[COORD_W-1:0];
    if (rv > 35'(COORD_MAX))  rsat = COORD_MAX;
    if (rv < -35'(COORD_MAX)) rsat = -COORD_MAX;
  end

  // Point loop bounds.
  logic [6:0] pt_den;
  logic       last_pt, last_m;
  assign pt_den  = kind_q ? {n_st_q, 1'b0} : n_sl_q;
  assign last_pt = kind_q ? (k_q == {1'b0, n_st_q}) : (k_q == n_sl_q - 7'd1);
  assign last_m  = (pass_q && kind_q) ? (mstep_q == 2'd2) : (mstep_q == 2'd1);

  // Multiplier operand select.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = HALF_PI_Q31;
    mul_b  = $signed(rem_ph);
    if (state_q == ST_ZMUL) begin
      mul_en = 1'b1;
    end else if (state_q == ST_MUL) begin
      mul_en = 1'b1;
      if (!pass_q) begin
        mul_a = MUL_A_W'({1'b0, radius_q});
        mul_b = (mstep_q == 2'd0) ? c_q : s_q;
      end else if (!kind_q) begin
        mul_a = MUL_A_W'(scale_q);
        mul_b = (mstep_q == 2'd0) ? c_q : s_q;
      end else begin
        case (mstep_q)
          2'd0: begin
            mul_a = MUL_A_W'(fixed_q);
            mul_b = s_q;
          end
          2'd1: begin
            mul_a = MUL_A_W'({1'b0, radius_q});
            mul_b = c_q;
          end
          default: begin
            mul_a = MUL_A_W'(scale_q);
            mul_b = s_q;
          end
        endcase
      end
    end
  end

  // Next state, divider launch and CORDIC launch.
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    div_num    = {1'b0, line_index_i};
    div_den    = kind_i ? n_sl_c : {n_st_c, 1'b0};
    cord_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !bad_req) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV:    if (div_done) state_d = ST_ZMUL;
      ST_ZMUL:   state_d = ST_CSTART;
      ST_CSTART: begin
        cord_start = 1'b1;
        state_d    = ST_CORD;
      end
      ST_CORD:   if (cord_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_RND;
      ST_RND: begin
        div_den = pt_den;
        div_num = pass_q ? (k_q + 7'd1) : 7'd0;
        if (!last_m) begin
          state_d = ST_MUL;
        end else if (pass_q && last_pt) begin
          state_d = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      pass_q  <= 1'b0;
      k_q     <= '0;
      mstep_q <= '0;
      kind_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      if (accept) begin
        kind_q <= kind_i;
        pass_q <= 1'b0;
        k_q    <= '0;
        if (bad_req) valid_q <= 1'b1;
      end
      if (state_q == ST_CORD) mstep_q <= '0;
      if (state_q == ST_RND) begin
        if (!last_m) begin
          mstep_q <= mstep_q + 2'd1;
        end else if (!pass_q) begin
          pass_q <= 1'b1;
        end else begin
          valid_q <= 1'b1;
          k_q     <= k_q + 7'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_sl_q <= n_sl_c;
      n_st_q <= n_st_c;
      if (bad_req) begin
        x_q      <= '0;
        y_q      <= '0;
        z_q      <= '0;
        closed_q <= 1'b0;
        last_q   <= 1'b1;
        bad_q    <= 1'b1;
      end
    end
    if (state_q == ST_ZMUL) quad_q <= quad;
    if (state_q == ST_CORD && cord_done) begin
      case (quad_q)
        2'd0: begin c_q <= cord_c;  s_q <= cord_s;  end
        2'd1: begin c_q <= -cord_s; s_q <= cord_c;  end
        2'd2: begin c_q <= -cord_c; s_q <= -cord_s; end
        default: begin c_q <= cord_s; s_q <= -cord_c; end
      endcase
    end
    if (state_q == ST_RND) begin
      if (!pass_q) begin
        if (mstep_q == 2'd0) fixed_q <= rsat;
        else scale_q <= rsat;
      end else if (!kind_q) begin
        if (mstep_q == 2'd0) begin
          x_q <= rsat;
          y_q <= fixed_q;
        end else begin
          z_q <= rsat;
        end
      end else begin
        case (mstep_q)
          2'd0: x_q <= rsat;
          2'd1: y_q <= rsat;
          default: z_q <= rsat;
        endcase
      end
      if (pass_q && last_m) begin
        closed_q <= !kind_q;
        last_q   <= last_pt;
        bad_q    <= 1'b0;
      end
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign vertex_valid_o = valid_q;
  assign vertex_x_o     = x_q;
  assign vertex_y_o     = y_q;
  assign vertex_z_o     = z_q;
  assign closed_loop_o  = closed_q;
  assign last_vertex_o  = last_q;
  assign bad_line_o     = bad_q;

`include "wire_sphere_vertex_generator_unit_macros.svh"

  `WSVG_ASSERT_NOW(a_bad_is_last, valid_q && bad_q, last_q, "flagged vertex not marked last")
  `WSVG_ASSERT_NOW(a_bad_zero, valid_q && bad_q, (x_q == '0) && (y_q == '0) && (z_q == '0), "flagged vertex has nonzero coordinates")
  `WSVG_ASSERT_NXT(a_req_taken, start && !busy, busy || valid_q, "request neither started nor answered")
  `WSVG_ASSERT_NOW(a_last_idle, valid_q && last_q && !bad_q, !busy, "busy after the last vertex")

endmodule
